// ----- hw/rtl/rse_pkg.sv -----
// Shared types and constants for the ribbon strip expander.
// No dependencies; every other file of the block imports this package.
package rse_pkg;

  localparam int POS_W      = 32;
  localparam int COL_W      = 32;
  localparam int NRM_W      = 16;
  localparam int CAM_W      = 16;
  localparam int TEX_W      = 17;
  localparam int CNT_W      = 17;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TEX_W-1:0] TEX_ONE        = 17'h10000;
  localparam logic [CNT_W-1:0] RST_COUNT      = 17'd2;
  localparam logic [COL_W-1:0] RST_COLOUR     = 32'hFFFF_FFFF;
  localparam logic [CAM_W-1:0] RST_CAMERA_Z   = 16'sd16384;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POINT_COUNT      = 3'd0,
    REG_INVERSE_NORMALS  = 3'd1,
    REG_USE_POINT_COLOUR = 3'd2,
    REG_CONSTANT_COLOUR  = 3'd3,
    REG_CAMERA_X         = 3'd4,
    REG_CAMERA_Y         = 3'd5,
    REG_CAMERA_Z         = 3'd6
  } rse_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic                    inverse_normals;
    logic                    use_point_colour;
    logic [COL_W-1:0]        constant_colour;
    logic signed [CAM_W-1:0] camera_x;
    logic signed [CAM_W-1:0] camera_y;
    logic signed [CAM_W-1:0] camera_z;
  } rse_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] prev_x;
    logic signed [POS_W-1:0] prev_y;
    logic signed [POS_W-1:0] prev_z;
    logic signed [POS_W-1:0] prev_w;
    logic [COL_W-1:0]        prev_col;
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic signed [POS_W-1:0] cur_z;
    logic signed [POS_W-1:0] cur_w;
    logic [COL_W-1:0]        cur_col;
    logic [CNT_W-1:0]        n;
    logic                    last;
  } rse_job_t;

  typedef struct packed {
    logic     push;
    rse_job_t job;
  } rse_push_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } rse_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } rse_div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_MAG,
    ST_NORM,
    ST_SQ,
    ST_ROOT,
    ST_DSTART,
    ST_DWAIT,
    ST_OFF,
    ST_LOAD,
    ST_EMIT
  } rse_state_t;

endpackage

// ----- hw/rtl/rse_point_if.sv -----
// Point channel: valid/ready handshake with one polyline point per word.
// Depends on rse_pkg for field widths.
interface rse_point_if import rse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [POS_W-1:0] half_width;
  logic [COL_W-1:0]        point_colour;

  modport source (output valid, pos_x, pos_y, pos_z, half_width, point_colour,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, half_width, point_colour,
                  output ready);
endinterface

// ----- hw/rtl/rse_vert_if.sv -----
// Vertex channel: valid/ready handshake with one strip vertex per word.
// Depends on rse_pkg for field widths.
interface rse_vert_if import rse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] vert_x;
  logic signed [POS_W-1:0] vert_y;
  logic signed [POS_W-1:0] vert_z;
  logic signed [NRM_W-1:0] norm_x;
  logic signed [NRM_W-1:0] norm_y;
  logic signed [NRM_W-1:0] norm_z;
  logic [TEX_W-1:0]        tex_s;
  logic                    tex_t;
  logic [COL_W-1:0]        vert_colour;
  logic                    strip_end;

  modport source (output valid, vert_x, vert_y, vert_z, norm_x, norm_y, norm_z,
                  tex_s, tex_t, vert_colour, strip_end, input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, norm_x, norm_y, norm_z,
                  tex_s, tex_t, vert_colour, strip_end, output ready);
endinterface

// ----- hw/rtl/rse_front.sv -----
// Front end: accepts points, tracks the previous point and ribbon index,
// and pushes one segment job per point after the first. Depends on rse_pkg.
module rse_front import rse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  rse_point_if.sink        points,
  input  logic [CNT_W-1:0] count,
  input  logic             full,
  output rse_push_t        push
);

  logic signed [POS_W-1:0] prev_x, prev_y, prev_z, prev_w;
  logic [COL_W-1:0]        prev_col;
  logic [CNT_W-1:0]        idx;
  logic                    accept;
  logic                    last;
  logic [CNT_W:0]          idx_inc;

  assign points.ready = !full;
  assign accept       = points.valid && !full;
  assign idx_inc      = {1'b0, idx} + (CNT_W+1)'(1);
  assign last         = idx_inc >= {1'b0, count};

  always_comb begin
    push.push         = accept && (idx != '0);
    push.job.prev_x   = prev_x;
    push.job.prev_y   = prev_y;
    push.job.prev_z   = prev_z;
    push.job.prev_w   = prev_w;
    push.job.prev_col = prev_col;
    push.job.cur_x    = points.pos_x;
    push.job.cur_y    = points.pos_y;
    push.job.cur_z    = points.pos_z;
    push.job.cur_w    = points.half_width;
    push.job.cur_col  = points.point_colour;
    push.job.n        = idx - CNT_W'(1);
    push.job.last     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      if (idx == '0) begin
        idx <= CNT_W'(1);
      end else if (last) begin
        idx <= '0;
      end else begin
        idx <= idx_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x   <= points.pos_x;
      prev_y   <= points.pos_y;
      prev_z   <= points.pos_z;
      prev_w   <= points.half_width;
      prev_col <= points.point_colour;
    end
  end

endmodule

// ----- hw/rtl/rse_queue.sv -----
// Two-entry job queue between front and back ends.
// Depends on rse_pkg for the job type.
module rse_queue import rse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rse_push_t wr,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output rse_job_t  head
);

  rse_job_t   q [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr.push) wp <= !wp;
      if (pop) rp <= !rp;
      case ({wr.push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) q[wp] <= wr.job;
  end

endmodule

// ----- hw/rtl/rse_div.sv -----
// Restoring divider, one quotient bit per cycle, 32 steps.
// Needs dividend[63:32] below the divisor. Depends on rse_pkg.
module rse_div import rse_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  rse_div_req_t req,
  output rse_div_res_t res
);

  logic [31:0] rem, dsh, quo, dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] r2;
  logic        ge;

  assign r2           = {rem, dsh[31]};
  assign ge           = r2 >= {1'b0, dvs};
  assign res.done     = busy && (cnt == '0);
  assign res.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[63:32];
      dsh <= req.dividend[31:0];
      dvs <= req.divisor;
      quo <= '0;
    end else if (busy && cnt != '0) begin
      rem <= ge ? 32'(r2 - {1'b0, dvs}) : r2[31:0];
      dsh <= {dsh[30:0], 1'b0};
      quo <= {quo[30:0], ge};
    end
  end

endmodule

// ----- hw/rtl/rse_back.sv -----
// Back end: cross product, normalisation, square root, divisions and
// vertex emission for one queued job at a time. Depends on rse_pkg, rse_div.
module rse_back import rse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rse_cfg_t  cfg,
  input  logic      empty,
  input  rse_job_t  head,
  output logic      pop,
  rse_vert_if.source vertices
);

  rse_state_t state, state_next;
  rse_job_t   job;

  logic signed [32:0]      lx, ly, lz;
  logic [48:0]             mag [3];
  logic [2:0]              neg;
  logic [48:0]             mx;
  logic [61:0]             sum;
  logic [61:0]             rv;
  logic [62:0]             rr, rbit;
  logic [4:0]              rcnt;
  logic signed [NRM_W-1:0] up [3];
  logic [TEX_W-1:0]        tq;
  logic [1:0]              di;
  logic [1:0]              k;
  logic signed [33:0]      off [3];
  logic                    pair;
  logic                    vt;

  logic signed [POS_W-1:0] ox, oy, oz;
  logic signed [NRM_W-1:0] on_x, on_y, on_z;
  logic [TEX_W-1:0]        ots;
  logic                    ott, ose;
  logic [COL_W-1:0]        ocol;

  rse_div_req_t dreq;
  rse_div_res_t dres;

  rse_div u_div (.clk(clk), .rst(rst), .req(dreq), .res(dres));

  // cross product, one component per cycle
  logic signed [32:0]       ma, mb;
  logic signed [CAM_W-1:0]  ca, cb;
  logic signed [48:0]       p1, p2;
  logic signed [49:0]       cr, crm;

  always_comb begin
    case (k)
      2'd0: begin ma = ly; ca = cfg.camera_z; mb = lz; cb = cfg.camera_y; end
      2'd1: begin ma = lz; ca = cfg.camera_x; mb = lx; cb = cfg.camera_z; end
      default: begin ma = lx; ca = cfg.camera_y; mb = ly; cb = cfg.camera_x; end
    endcase
  end

  assign p1  = 49'(ma) * 49'(ca);
  assign p2  = 49'(mb) * 49'(cb);
  assign cr  = p1 - p2;
  assign crm = cr[49] ? -cr : cr;

  logic [48:0] m01, mx_c;
  assign m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign mx_c = (m01 > mag[2]) ? m01 : mag[2];

  logic in_rng, big;
  assign big    = |mx[48:30];
  assign in_rng = !big && mx[29];

  logic [59:0] sq;
  assign sq = 60'(mag[0][29:0]) * 60'(mag[0][29:0]);

  logic [63:0] rt;
  logic        rge;
  assign rt  = {1'b0, rr} + {1'b0, rbit};
  assign rge = {2'b0, rv} >= rt;

  // offset = floor((up*w + half) / 2^14)
  logic signed [POS_W-1:0] wsel;
  logic signed [47:0]      prod;
  logic signed [48:0]      prnd;
  assign wsel = pair ? job.cur_w : job.prev_w;
  assign prod = 48'(up[0]) * 48'(wsel);
  assign prnd = prod + 49'sd8192;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [31:0] place(input logic signed [31:0] p,
                                        input logic signed [33:0] o,
                                        input logic plus);
    logic signed [34:0] pe, oe;
    pe = {{3{p[31]}}, p};
    oe = {o[33], o};
    place = sat32(plus ? pe + oe : pe - oe);
  endfunction

  logic neg_n;
  assign neg_n = vt ~^ cfg.inverse_normals;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!empty) state_next = ST_CROSS;
      ST_CROSS:  if (k == 2'd2) state_next = ST_MAG;
      ST_MAG:    state_next = (mx_c == '0) ? ST_DSTART : ST_NORM;
      ST_NORM:   if (in_rng) state_next = ST_SQ;
      ST_SQ:     if (k == 2'd2) state_next = ST_ROOT;
      ST_ROOT:   if (rcnt == '0) state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (dres.done) state_next = (di == 2'd3) ? ST_OFF : ST_DSTART;
      ST_OFF:    if (k == 2'd2) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (vertices.ready) begin
          if (!vt) state_next = ST_LOAD;
          else if (!pair && job.last) state_next = ST_OFF;
          else state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop            = (state == ST_IDLE) && !empty;
    vertices.valid = state == ST_EMIT;
    dreq.start     = state == ST_DSTART;
    if (di == 2'd3) begin
      dreq.dividend = {31'd0, job.n, 16'd0};
      dreq.divisor  = {15'd0, cfg.count};
    end else begin
      dreq.dividend = {20'd0, mag[0][29:0], 14'd0} + {33'd0, rr[31:1]};
      dreq.divisor  = rr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          job <= head;
          lx  <= {head.cur_x[31], head.cur_x} - {head.prev_x[31], head.prev_x};
          ly  <= {head.cur_y[31], head.cur_y} - {head.prev_y[31], head.prev_y};
          lz  <= {head.cur_z[31], head.cur_z} - {head.prev_z[31], head.prev_z};
          k   <= 2'd0;
        end
      end
      ST_CROSS: begin
        mag[0] <= mag[1];
        mag[1] <= mag[2];
        mag[2] <= crm[48:0];
        neg    <= {cr[49], neg[2:1]};
        k      <= k + 2'd1;
      end
      ST_MAG: begin
        mx  <= mx_c;
        sum <= '0;
        k   <= 2'd0;
        if (mx_c == '0) begin
          up[0] <= '0;
          up[1] <= '0;
          up[2] <= '0;
          di    <= 2'd3;
        end else begin
          di <= 2'd0;
        end
      end
      ST_NORM: begin
        if (big) begin
          mag[0] <= mag[0] >> 1;
          mag[1] <= mag[1] >> 1;
          mag[2] <= mag[2] >> 1;
          mx     <= mx >> 1;
        end else if (!mx[29]) begin
          mag[0] <= mag[0] << 1;
          mag[1] <= mag[1] << 1;
          mag[2] <= mag[2] << 1;
          mx     <= mx << 1;
        end
      end
      ST_SQ: begin
        sum    <= sum + {2'b0, sq};
        mag[0] <= mag[1];
        mag[1] <= mag[2];
        mag[2] <= mag[0];
        neg    <= {neg[0], neg[2:1]};
        k      <= k + 2'd1;
        if (k == 2'd2) begin
          rv   <= sum + {2'b0, sq};
          rr   <= '0;
          rbit <= 63'h4000_0000_0000_0000;
          rcnt <= 5'd31;
        end
      end
      ST_ROOT: begin
        if (rge) begin
          rv <= rv - rt[61:0];
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit <= rbit >> 2;
        rcnt <= rcnt - 5'd1;
      end
      ST_DWAIT: begin
        if (dres.done) begin
          di <= di + 2'd1;
          if (di == 2'd3) begin
            tq   <= dres.quotient[TEX_W-1:0];
            k    <= 2'd0;
            pair <= 1'b0;
          end else begin
            up[0]  <= up[1];
            up[1]  <= up[2];
            up[2]  <= neg[0] ? -$signed(dres.quotient[15:0]) :
                               $signed(dres.quotient[15:0]);
            mag[0] <= mag[1];
            mag[1] <= mag[2];
            mag[2] <= mag[0];
            neg    <= {neg[0], neg[2:1]};
          end
        end
      end
      ST_OFF: begin
        off[0] <= off[1];
        off[1] <= off[2];
        off[2] <= prnd[47:14];
        up[0]  <= up[1];
        up[1]  <= up[2];
        up[2]  <= up[0];
        k      <= k + 2'd1;
        vt     <= 1'b0;
      end
      ST_LOAD: begin
        ox   <= place(pair ? job.cur_x : job.prev_x, off[0], vt);
        oy   <= place(pair ? job.cur_y : job.prev_y, off[1], vt);
        oz   <= place(pair ? job.cur_z : job.prev_z, off[2], vt);
        on_x <= neg_n ? -up[0] : up[0];
        on_y <= neg_n ? -up[1] : up[1];
        on_z <= neg_n ? -up[2] : up[2];
        ots  <= pair ? TEX_ONE : tq;
        ott  <= vt;
        ocol <= cfg.use_point_colour ? (pair ? job.cur_col : job.prev_col) :
                                       cfg.constant_colour;
        ose  <= pair && vt;
      end
      ST_EMIT: begin
        if (vertices.ready) begin
          if (!vt) begin
            vt <= 1'b1;
          end else if (!pair && job.last) begin
            pair <= 1'b1;
            k    <= 2'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign vertices.vert_x      = ox;
  assign vertices.vert_y      = oy;
  assign vertices.vert_z      = oz;
  assign vertices.norm_x      = on_x;
  assign vertices.norm_y      = on_y;
  assign vertices.norm_z      = on_z;
  assign vertices.tex_s       = ots;
  assign vertices.tex_t       = ott;
  assign vertices.vert_colour = ocol;
  assign vertices.strip_end   = ose;

endmodule

// ----- hw/rtl/ribbon_strip_expander.sv -----
// Ribbon strip expander top level: configuration registers, front end,
// job queue and back end. Depends on rse_pkg, rse_point_if, rse_vert_if,
// rse_front, rse_queue, rse_back.
//
// Usage: stream polyline points on "points", one word per point. The first
// point of a ribbon gives no vertices; each later point gives the bottom and
// top strip vertices of the point before it, and the last point of the
// ribbon (point_count points) also gives its own pair, the top one flagged
// with strip_end. Vertices leave on "vertices" in order.
// Configuration: write register cfg_index with cfg_data while cfg_we is high;
// write only while no point is in flight.
// Flow: one point is worked at a time in the back end. The bit-serial square
// root and up to four divisions on one shared divider set the time per point.
// A two-entry job queue lets the front end take further points while the back
// end works or while a vertex waits on a stalled receiver; the front end stalls
// only when that queue is full.
// Reset: registers return to their defaults and a new ribbon starts.
module ribbon_strip_expander import rse_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rse_point_if.sink             points,
  rse_vert_if.source            vertices
);

  logic [CNT_W-1:0]        point_count;
  logic                    inverse_normals;
  logic                    use_point_colour;
  logic [COL_W-1:0]        constant_colour;
  logic signed [CAM_W-1:0] camera_x, camera_y, camera_z;

  rse_cfg_t  cfg;
  rse_push_t push;
  rse_job_t  head;
  logic      full, empty, pop;

  // register writes; indices past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count      <= RST_COUNT;
      inverse_normals  <= 1'b0;
      use_point_colour <= 1'b0;
      constant_colour  <= RST_COLOUR;
      camera_x         <= '0;
      camera_y         <= '0;
      camera_z         <= RST_CAMERA_Z;
    end else if (cfg_we) begin
      case (rse_reg_t'(cfg_index))
        REG_POINT_COUNT:      point_count      <= cfg_data[CNT_W-1:0];
        REG_INVERSE_NORMALS:  inverse_normals  <= cfg_data[0];
        REG_USE_POINT_COLOUR: use_point_colour <= cfg_data[0];
        REG_CONSTANT_COLOUR:  constant_colour  <= cfg_data[COL_W-1:0];
        REG_CAMERA_X:         camera_x         <= cfg_data[CAM_W-1:0];
        REG_CAMERA_Y:         camera_y         <= cfg_data[CAM_W-1:0];
        REG_CAMERA_Z:         camera_z         <= cfg_data[CAM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp the point count to [2, MAX_POINTS]
  always_comb begin
    if (point_count < CNT_W'(2)) begin
      cfg.count = CNT_W'(2);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      cfg.count = CNT_W'(MAX_POINTS);
    end else begin
      cfg.count = point_count;
    end
    cfg.inverse_normals  = inverse_normals;
    cfg.use_point_colour = use_point_colour;
    cfg.constant_colour  = constant_colour;
    cfg.camera_x         = camera_x;
    cfg.camera_y         = camera_y;
    cfg.camera_z         = camera_z;
  end

  rse_front u_front (
    .clk(clk), .rst(rst), .points(points), .count(cfg.count),
    .full(full), .push(push)
  );

  rse_queue u_queue (
    .clk(clk), .rst(rst), .wr(push), .pop(pop),
    .full(full), .empty(empty), .head(head)
  );

  rse_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .empty(empty), .head(head),
    .pop(pop), .vertices(vertices)
  );

endmodule

// ----- tb/sv/ribbon_strip_expander_test.sv -----
// Self-checking testbench for the ribbon strip expander.
// Depends on rse_pkg, rse_point_if, rse_vert_if and ribbon_strip_expander.
// Streams polylines through the block and checks each vertex against a predictor.
`timescale 1ns / 100ps

module ribbon_strip_expander_test;
  import rse_pkg::*;

  localparam int MAX_PTS    = 65536;
  localparam int IDLE_WAIT  = 300;   // slowest point through the back end, with margin
  localparam int STALL_LIM  = 5000;  // cycles with no word moving on either side

  typedef struct {
    logic signed [POS_W-1:0] x, y, z;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic [TEX_W-1:0]        s;
    logic                    t;
    logic [COL_W-1:0]        col;
    logic                    strip_end;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rse_point_if pt();
  rse_vert_if  vx();

  ribbon_strip_expander u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .points(pt), .vertices(vx)
  );

  always #1 clk = ~clk;

  // Shadow of the configuration registers and the ribbon state.
  logic [CNT_W-1:0]        sh_count = RST_COUNT;
  logic                    sh_inv = 1'b0;
  logic                    sh_use_col = 1'b0;
  logic [COL_W-1:0]        sh_const_col = RST_COLOUR;
  logic signed [CAM_W-1:0] sh_cam_x = '0, sh_cam_y = '0, sh_cam_z = RST_CAMERA_Z;
  logic signed [POS_W-1:0] last_x = '0, last_y = '0, last_z = '0, last_w = '0;
  logic [COL_W-1:0]        last_col = '0;
  int unsigned             pt_idx = 0;

  vertex_t pending_verts[$];
  int      errors = 0;
  bit      idle_on = 1'b1;   // random gaps on both sides
  int      hold_req = 0;     // long receiver hold-off, in cycles

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Floor integer square root.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit up vector in Q2.14 from the exact cross product; zero stays zero.
  function automatic void unit_up(input longint c[3], output int up[3]);
    longint unsigned mag[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      up = '{0, 0, 0};
      return;
    end
    // bring the largest magnitude into [2^29, 2^30)
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + len / 2) / len;
      up[i] = (c[i] < 0) ? -int'(q) : int'(q);
    end
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Queue the bottom and top vertices of one point.
  function automatic void push_pair(longint pos[3], longint w, int up[3],
                                    logic [TEX_W-1:0] s, logic [COL_W-1:0] col,
                                    bit ends);
    vertex_t v;
    longint off[3], sgn, nsg;
    for (int i = 0; i < 3; i++) off[i] = (longint'(up[i]) * w + 8192) >>> 14;
    for (int k = 0; k < 2; k++) begin
      sgn = k ? 1 : -1;
      nsg = sh_inv ? -sgn : sgn;
      v.x = sat_pos(pos[0] + sgn * off[0]);
      v.y = sat_pos(pos[1] + sgn * off[1]);
      v.z = sat_pos(pos[2] + sgn * off[2]);
      v.nx = NRM_W'(nsg * up[0]);
      v.ny = NRM_W'(nsg * up[1]);
      v.nz = NRM_W'(nsg * up[2]);
      v.s = s;
      v.t = k[0];
      v.col = col;
      v.strip_end = ends && (k == 1);
      pending_verts.push_back(v);
    end
  endfunction

  // Work out the vertices that one accepted point causes and advance the ribbon.
  function automatic void predict_point(logic signed [POS_W-1:0] px, py, pz, pw,
                                        logic [COL_W-1:0] pc);
    longint unsigned cnt;
    longint line[3], cr[3], prv[3], cur[3];
    int up[3];
    bit is_last;
    cnt = sh_count;
    if (cnt < 2) cnt = 2;
    if (cnt > MAX_PTS) cnt = MAX_PTS;
    if (pt_idx != 0) begin
      prv = '{last_x, last_y, last_z};
      cur = '{px, py, pz};
      for (int i = 0; i < 3; i++) line[i] = cur[i] - prv[i];
      cr[0] = line[1] * sh_cam_z - line[2] * sh_cam_y;
      cr[1] = line[2] * sh_cam_x - line[0] * sh_cam_z;
      cr[2] = line[0] * sh_cam_y - line[1] * sh_cam_x;
      unit_up(cr, up);
      is_last = (pt_idx + 1) >= cnt;
      push_pair(prv, last_w, up, TEX_W'((longint'(pt_idx - 1) * 65536) / cnt),
                sh_use_col ? last_col : sh_const_col, 1'b0);
      if (is_last) begin
        push_pair(cur, pw, up, TEX_ONE, sh_use_col ? pc : sh_const_col, 1'b1);
        pt_idx = 0;
      end else begin
        pt_idx++;
      end
    end else begin
      pt_idx = 1;
    end
    last_x = px; last_y = py; last_z = pz; last_w = pw; last_col = pc;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic write_reg(rse_reg_t idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      REG_POINT_COUNT:      sh_count = d[CNT_W-1:0];
      REG_INVERSE_NORMALS:  sh_inv = d[0];
      REG_USE_POINT_COLOUR: sh_use_col = d[0];
      REG_CONSTANT_COLOUR:  sh_const_col = d;
      REG_CAMERA_X:         sh_cam_x = d[CAM_W-1:0];
      REG_CAMERA_Y:         sh_cam_y = d[CAM_W-1:0];
      REG_CAMERA_Z:         sh_cam_z = d[CAM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(int cx, int cy, int cz);
    write_reg(REG_CAMERA_X, CFG_DATA_W'(cx));
    write_reg(REG_CAMERA_Y, CFG_DATA_W'(cy));
    write_reg(REG_CAMERA_Z, CFG_DATA_W'(cz));
  endtask

  // Offer one point and hold it until the block takes it.
  task automatic send_point(logic signed [POS_W-1:0] px, py, pz, pw,
                            logic [COL_W-1:0] pc);
    int gap;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(10, 1);
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt.valid <= 1'b1;
    pt.pos_x <= px;
    pt.pos_y <= py;
    pt.pos_z <= pz;
    pt.half_width <= pw;
    pt.point_colour <= pc;
    do @(posedge clk); while (!pt.ready);
    predict_point(px, py, pz, pw, pc);
  endtask

  // Stop offering at the edge that took the last point, wait for every vertex,
  // then let the back end settle so a config write lands on an idle block.
  task automatic drain();
    pt.valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] rand_coord(bit wide);
    if (wide) return $urandom();
    return POS_W'($signed($urandom_range(32'h1F_FFFF)) - 32'sh10_0000);
  endfunction

  // One ribbon of n points with random content.
  task automatic send_ribbon(int n, bit wide);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(wide), rand_coord(wide), rand_coord(wide),
                 wide ? $urandom() : $urandom_range(32'h4_0000), $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [63:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      $display("%0t vertex %s mismatch: expected %h actual %h", $realtime, name,
               exp_v, got_v);
      errors++;
    end
  endfunction

  int burst_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && vx.valid && vx.ready) begin
      if (pending_verts.size() == 0) begin
        $display("%0t unexpected vertex: expected none actual x=%h", $realtime, vx.vert_x);
        errors++;
      end else begin
        e = pending_verts.pop_front();
        check_field("vert_x", e.x, vx.vert_x);
        check_field("vert_y", e.y, vx.vert_y);
        check_field("vert_z", e.z, vx.vert_z);
        check_field("norm_x", e.nx, vx.norm_x);
        check_field("norm_y", e.ny, vx.norm_y);
        check_field("norm_z", e.nz, vx.norm_z);
        check_field("tex_s", e.s, vx.tex_s);
        check_field("tex_t", e.t, vx.tex_t);
        check_field("vert_colour", e.col, vx.vert_colour);
        check_field("strip_end", e.strip_end, vx.strip_end);
      end
    end
    // Pick ready for the next edge: a requested hold-off wins, then random bursts.
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      vx.ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      vx.ready <= 1'b0;
    end else if (idle_on && $urandom_range(4) == 0) begin
      burst_left = $urandom_range(9);
      vx.ready <= 1'b0;
    end else begin
      vx.ready <= 1'b1;
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((pt.valid && pt.ready) || (vx.valid && vx.ready) || rst) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIM) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: two-point ribbons, camera along z, constant colour.
  task automatic test_defaults();
    send_point(32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0000_8000, 32'h1122_3344);
    send_point(32'sh0003_0000, 32'sh0002_0000, 32'sh0, 32'sh0001_0000, 32'h5566_7788);
    send_ribbon(2, 1'b0);
    drain();
  endtask

  // Field extremes: saturation both ways, widest widths, all-ones and zero colours.
  task automatic test_field_extremes();
    write_reg(REG_POINT_COUNT, 4);
    write_reg(REG_USE_POINT_COLOUR, 1);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hA5A5_5A5A);
    send_point(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'h5A5A_A5A5);
    drain();
  endtask

  // Inverted normals, constant colour extremes and two off-axis camera settings.
  task automatic test_normals_and_colour();
    write_reg(REG_INVERSE_NORMALS, 1);
    write_reg(REG_USE_POINT_COLOUR, 0);
    write_reg(REG_CONSTANT_COLOUR, 32'h0);
    set_camera(-16384, 16384, -16384);
    write_reg(REG_POINT_COUNT, 3);
    send_ribbon(3, 1'b0);
    drain();
    write_reg(REG_CONSTANT_COLOUR, 32'hFFFF_FFFF);
    set_camera(16384, -16384, 0);
    send_ribbon(3, 1'b1);
    drain();
    write_reg(REG_INVERSE_NORMALS, 0);
  endtask

  // Zero cross product: repeated point, segment along the camera, zero camera.
  task automatic test_degenerate();
    set_camera(0, 0, 16384);
    write_reg(REG_POINT_COUNT, 3);
    send_point(32'sh0005_0000, 32'sh0006_0000, 32'sh0, 32'sh0002_0000, 32'h1);
    send_point(32'sh0005_0000, 32'sh0006_0000, 32'sh0, 32'sh0002_0000, 32'h2);
    send_point(32'sh0005_0000, 32'sh0006_0000, 32'sh0009_0000, 32'sh0002_0000, 32'h3);
    drain();
    set_camera(0, 0, 0);
    send_ribbon(3, 1'b0);
    drain();
  endtask

  // Count extremes: full size, over range, below range, and lowered mid ribbon.
  task automatic test_count_limits();
    set_camera(1000, -2000, 12000);
    write_reg(REG_POINT_COUNT, MAX_PTS);
    send_ribbon(5, 1'b0);
    drain();
    write_reg(REG_POINT_COUNT, 3);       // index already past count-1: ends now
    send_ribbon(1, 1'b0);
    drain();
    write_reg(REG_POINT_COUNT, 32'h1_FFFF);   // acts as the maximum
    send_ribbon(3, 1'b0);
    drain();
    write_reg(REG_POINT_COUNT, 0);       // acts as two
    send_ribbon(1, 1'b0);
    drain();
    write_reg(REG_POINT_COUNT, 1);
    send_ribbon(2, 1'b0);
    drain();
  endtask

  // Hold the receiver off long enough for the job queue to fill and stall points.
  task automatic test_backpressure();
    write_reg(REG_POINT_COUNT, 4);
    hold_req = 800;
    send_ribbon(8, 1'b0);
    drain();
  endtask

  // Random ribbons under random settings; the last part runs with no idling.
  task automatic test_random(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if (sent > (n_items * 3) / 4) idle_on = 1'b0;
      write_reg(REG_POINT_COUNT, $urandom_range(7, 2));
      write_reg(REG_INVERSE_NORMALS, $urandom_range(1));
      write_reg(REG_USE_POINT_COLOUR, $urandom_range(1));
      write_reg(REG_CONSTANT_COLOUR, $urandom());
      set_camera($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                 $urandom_range(32768) - 16384);
      // a few ribbons per setting; now and then a short broken ribbon left open
      for (int r = 0; r < 3; r++) begin
        len = (sh_count < 2) ? 2 : int'(sh_count);
        if ($urandom_range(7) == 0) len = $urandom_range(len, 1);
        send_ribbon(len, $urandom_range(3) == 0);
        sent += len;
      end
      drain();
      // close any open ribbon so the next setting starts clean
      while (pt_idx != 0) begin
        send_ribbon(1, 1'b0);
        sent++;
      end
      drain();
    end
  endtask

  initial begin
    pt.valid = 1'b0;
    pt.pos_x = '0;
    pt.pos_y = '0;
    pt.pos_z = '0;
    pt.half_width = '0;
    pt.point_colour = '0;
    vx.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_field_extremes();
    test_normals_and_colour();
    test_degenerate();
    test_count_limits();
    test_backpressure();
    test_random(120);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- ribbon_strip_expander.f -----
hw/rtl/rse_pkg.sv
hw/rtl/rse_point_if.sv
hw/rtl/rse_vert_if.sv
hw/rtl/rse_front.sv
hw/rtl/rse_queue.sv
hw/rtl/rse_div.sv
hw/rtl/rse_back.sv
hw/rtl/ribbon_strip_expander.sv
tb/sv/ribbon_strip_expander_test.sv
